@@ hdl/pqpw_pkg.sv @@
`timescale 1ns / 1ps
// Package for the piecewise-quadratic position warp: shared constants, register
// indexes, term classes and the control struct handed to the divider pipeline.
// No dependencies.
package pqpw_pkg;

  localparam int POS_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;

  // Gain is unsigned Q8.8.
  localparam int GAIN_W = 16;
  localparam int GAIN_FRAC = 8;
  localparam logic [GAIN_W-1:0] GAIN_ONE = 16'd256;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd1280;

  // Ramp length after reset, in whole position units.
  localparam int LEN_RESET_INT = 113;

  localparam int REG_IDX_W = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_ENABLE   = 3'd0,
    REG_MODE     = 3'd1,
    REG_GAIN     = 3'd2,
    REG_RAMP_LEN = 3'd3,
    REG_CENTER   = 3'd4
  } reg_idx_t;

  // Which form the added term takes for one position.
  typedef enum logic [2:0] {
    CLS_ZERO,
    CLS_RAMP,
    CLS_MID,
    CLS_LIN_SLOPE,
    CLS_LIN_PEAK
  } term_cls_t;

  typedef struct packed {
    logic valid;
    logic neg;
  } div_ctl_t;

endpackage

@@ hdl/piecewise_quadratic_position_warp.sv @@
`timescale 1ns / 1ps
// Top level of the piecewise-quadratic position warp: configuration registers,
// term setup pipeline and output saturation. Depends on pqpw_pkg and pqpw_div.
//
// Usage: positions stream in on the in_ channel (one signed fixed-point position per
// request) and the warped, saturated positions stream out on the out_ channel in the
// same order, one result per request. The warp is set through the APB-style cfg_ port:
// enable at 0x0, warp_mode at 0x4, gain at 0x8, ramp_length at 0xC and center at 0x10
// (stride 8 and 64-bit data when POS_WIDTH is above 32). Writes complete in the access
// cycle, pready is tied high, and registers should only be changed while no request is
// in flight.
//
// Throughput is one request per clock when not stalled. Each request passes through
// POS_WIDTH + 10 register stages (42 at the default width): six stages that build the
// numerator and divisor of the added term, a divider that resolves one quotient bit per
// stage plus an overflow check, and the output register. Divider depth sets latency.
//
// Reset (synchronous, active low) empties the pipeline and loads the register defaults:
// disabled, slope mode, gain 5.0, ramp length 113.0, center 0. When the receiver holds
// out_tready low with a result waiting, the whole pipeline freezes and in_tready drops;
// nothing is lost or repeated, and it resumes in the cycle out_tready returns.
module piecewise_quadratic_position_warp import pqpw_pkg::*; #(
  parameter int POS_WIDTH = POS_WIDTH_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int TDATA_W  = ((POS_WIDTH + 7) / 8) * 8,
  localparam int CFG_DW   = (POS_WIDTH > 32) ? 64 : 32,
  localparam int ADDR_LSB = (POS_WIDTH > 32) ? 3 : 2,
  localparam int ADDR_W   = ADDR_LSB + REG_IDX_W
) (
  input  logic               clk,
  input  logic               rst_n,
  // Input requests.
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [TDATA_W-1:0] in_tdata,    // [POS_WIDTH-1:0] position_in
  // Results.
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata,   // [POS_WIDTH-1:0] position_out
  // Configuration.
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [ADDR_W-1:0]  cfg_paddr,
  input  logic [CFG_DW-1:0]  cfg_pwdata,
  output logic [CFG_DW-1:0]  cfg_prdata,
  output logic               cfg_pready
);

  localparam int W   = POS_WIDTH;
  localparam int LW  = W - 1;                 // ramp length width
  localparam int SQW = 2 * W - 2;             // square of a value below the ramp length
  localparam int NW  = 2 * W - 1;             // numerator, up to 2*L^2
  localparam int NMW = NW + GAIN_W;           // numerator times |K - 1|
  localparam int XW  = NMW + 1;               // plus half the divisor
  localparam int DW  = LW + GAIN_FRAC + 1;    // divisor, up to L * 2.0 in gain units
  localparam int QW  = W + 2;                 // quotient bits kept before saturation

  localparam logic [LW-1:0] LEN_RESET = LW'(64'(LEN_RESET_INT) << FRAC_BITS);
  localparam logic [W-1:0]  POS_MAX   = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]  POS_MIN   = {1'b1, {(W-1){1'b0}}};

  // ---------------------------------------------------------------------------
  // Configuration registers.
  // ---------------------------------------------------------------------------
  logic              enable_r;
  logic              mode_r;
  logic [GAIN_W-1:0] gain_r;
  logic [LW-1:0]     len_r;
  logic [W-1:0]      center_r;
  logic              cfg_wr;
  reg_idx_t          cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[ADDR_LSB +: REG_IDX_W]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      mode_r   <= 1'b0;
      gain_r   <= GAIN_RESET;
      len_r    <= LEN_RESET;
      center_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ENABLE:   enable_r <= cfg_pwdata[0];
        REG_MODE:     mode_r   <= cfg_pwdata[0];
        REG_GAIN:     gain_r   <= cfg_pwdata[GAIN_W-1:0];
        REG_RAMP_LEN: len_r    <= cfg_pwdata[LW-1:0];
        REG_CENTER:   center_r <= cfg_pwdata[W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    unique case (cfg_idx)
      REG_ENABLE:   cfg_prdata = CFG_DW'(enable_r);
      REG_MODE:     cfg_prdata = CFG_DW'(mode_r);
      REG_GAIN:     cfg_prdata = CFG_DW'(gain_r);
      REG_RAMP_LEN: cfg_prdata = CFG_DW'(len_r);
      REG_CENTER:   cfg_prdata = CFG_DW'(center_r);
      default:      cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline control. Every stage moves together; the pipeline only stops when a
  // result sits in the output register and the receiver is not taking it.
  // ---------------------------------------------------------------------------
  logic adv;
  logic out_valid_r;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;

  // Stage 1: offset from the center.
  logic                v1_r;
  logic [W-1:0]        p1_r;
  logic signed [W:0]   d1_r;
  logic signed [W:0]   d1_nxt;

  assign d1_nxt = $signed({in_tdata[W-1], in_tdata[W-1:0]}) -
                  $signed({center_r[W-1], center_r});

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (adv) v1_r <= in_tvalid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_r <= in_tdata[W-1:0];
      d1_r <= d1_nxt;
    end
  end

  // Stage 2: pick the segment, the value to square and the linear numerator.
  logic signed [W+1:0] d1x;
  logic signed [W+1:0] lenx;
  logic signed [W+1:0] e_s2;
  logic signed [W+1:0] dml_s2;
  logic signed [W+1:0] lmd_s2;
  logic signed [W+1:0] lin_s2;
  term_cls_t           cls_nxt;
  logic [LW-1:0]       x_nxt;
  logic [W:0]          lin_nxt;

  logic                v2_r;
  logic [W-1:0]        p2_r;
  term_cls_t           cls2_r;
  logic [LW-1:0]       x2_r;
  logic [W:0]          lin2_r;

  assign d1x    = {d1_r[W], d1_r};
  assign lenx   = {3'b000, len_r};
  assign e_s2   = d1x + lenx;
  assign dml_s2 = d1x - lenx;
  assign lmd_s2 = lenx - d1x;
  assign lin_s2 = d1x + dml_s2;   // 2d - L

  always_comb begin
    cls_nxt = CLS_ZERO;
    x_nxt   = '0;
    lin_nxt = '0;
    if (!mode_r) begin
      if (d1x[W+1] || d1x == '0) begin
        cls_nxt = CLS_ZERO;
      end else if (dml_s2[W+1]) begin
        cls_nxt = CLS_RAMP;
        x_nxt   = d1x[LW-1:0];
      end else begin
        cls_nxt = CLS_LIN_SLOPE;
        lin_nxt = lin_s2[W:0];
      end
    end else begin
      if (e_s2[W+1] || e_s2 == '0) begin
        cls_nxt = CLS_ZERO;
      end else if (d1x[W+1]) begin
        // Rising half of the peak.
        cls_nxt = CLS_RAMP;
        x_nxt   = e_s2[LW-1:0];
      end else if (dml_s2[W+1]) begin
        // Falling half: 2L^2 - (L - d)^2.
        cls_nxt = CLS_MID;
        x_nxt   = lmd_s2[LW-1:0];
      end else begin
        cls_nxt = CLS_LIN_PEAK;
        lin_nxt = {2'b00, len_r};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (adv) v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p2_r   <= p1_r;
      cls2_r <= cls_nxt;
      x2_r   <= x_nxt;
      lin2_r <= lin_nxt;
    end
  end

  // Stage 3: squares.
  logic           v3_r;
  logic [W-1:0]   p3_r;
  term_cls_t      cls3_r;
  logic [SQW-1:0] sq3_r;
  logic [SQW-1:0] ll3_r;
  logic [W:0]     lin3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (adv) v3_r <= v2_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p3_r   <= p2_r;
      cls3_r <= cls2_r;
      sq3_r  <= x2_r * x2_r;
      ll3_r  <= len_r * len_r;
      lin3_r <= lin2_r;
    end
  end

  // Stage 4: numerator and divisor of the term.
  logic          v4_r;
  logic [W-1:0]  p4_r;
  logic [NW-1:0] n4_r;
  logic [DW-1:0] den4_r;
  logic [NW-1:0] n_nxt;
  logic [DW-1:0] den_nxt;

  always_comb begin
    case (cls3_r)
      CLS_RAMP: begin
        n_nxt   = {1'b0, sq3_r};
        den_nxt = {len_r, {(GAIN_FRAC+1){1'b0}}};
      end
      CLS_MID: begin
        n_nxt   = {ll3_r, 1'b0} - {1'b0, sq3_r};
        den_nxt = {len_r, {(GAIN_FRAC+1){1'b0}}};
      end
      CLS_LIN_SLOPE: begin
        n_nxt   = {{(NW-W-1){1'b0}}, lin3_r};
        den_nxt = {{(DW-GAIN_W-1){1'b0}}, GAIN_ONE, 1'b0};
      end
      CLS_LIN_PEAK: begin
        n_nxt   = {{(NW-W-1){1'b0}}, lin3_r};
        den_nxt = {{(DW-GAIN_W){1'b0}}, GAIN_ONE};
      end
      default: begin
        n_nxt   = '0;
        den_nxt = {{(DW-GAIN_W){1'b0}}, GAIN_ONE};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (adv) v4_r <= v3_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p4_r   <= p3_r;
      n4_r   <= n_nxt;
      den4_r <= den_nxt;
    end
  end

  // Stage 5: scale by |K - 1|; the sign is applied after rounding.
  logic              v5_r;
  logic [W-1:0]      p5_r;
  logic [NMW-1:0]    nm5_r;
  logic [DW-1:0]     den5_r;
  logic              neg5_r;
  logic              neg_nxt;
  logic [GAIN_W-1:0] gmag;

  assign neg_nxt = gain_r < GAIN_ONE;
  assign gmag    = neg_nxt ? (GAIN_ONE - gain_r) : (gain_r - GAIN_ONE);

  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else if (adv) v5_r <= v4_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p5_r   <= p4_r;
      nm5_r  <= n4_r * gmag;
      den5_r <= den4_r;
      neg5_r <= neg_nxt;
    end
  end

  // Stage 6: add half the divisor so the divider's floor rounds half up.
  logic          v6_r;
  logic [W-1:0]  p6_r;
  logic [XW-1:0] x6_r;
  logic [DW-1:0] den6_r;
  logic          neg6_r;
  div_ctl_t      ctl6;

  always_ff @(posedge clk) begin
    if (!rst_n) v6_r <= 1'b0;
    else if (adv) v6_r <= v5_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p6_r   <= p5_r;
      x6_r   <= {1'b0, nm5_r} + {{(XW-DW+1){1'b0}}, den5_r[DW-1:1]};
      den6_r <= den5_r;
      neg6_r <= neg5_r;
    end
  end

  assign ctl6 = '{valid: v6_r, neg: neg6_r};

  // Divider.
  div_ctl_t      dv_ctl;
  logic [QW-1:0] dv_q;
  logic          dv_ovf;
  logic [W-1:0]  dv_p;

  pqpw_div #(
    .DW (DW),
    .XW (XW),
    .QW (QW),
    .TW (W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_ctl  (ctl6),
    .in_x    (x6_r),
    .in_den  (den6_r),
    .in_tag  (p6_r),
    .out_ctl (dv_ctl),
    .out_q   (dv_q),
    .out_ovf (dv_ovf),
    .out_tag (dv_p)
  );

  // Output stage: apply the sign, add to the position and saturate.
  logic [W+3:0] dq;
  logic [W+3:0] delta;
  logic [W+3:0] sum;
  logic         sum_fits;
  logic [W-1:0] res_nxt;
  logic [W-1:0] out_pos_r;

  assign dq       = {2'b00, dv_q};
  assign delta    = dv_ctl.neg ? (~dq + 1'b1) : dq;
  assign sum      = {{4{dv_p[W-1]}}, dv_p} + delta;
  assign sum_fits = (sum[W+3:W-1] == '0) || (sum[W+3:W-1] == '1);

  always_comb begin
    if (!enable_r) begin
      res_nxt = dv_p;
    end else if (dv_ovf) begin
      // A quotient this large pushes any position past the range.
      res_nxt = dv_ctl.neg ? POS_MIN : POS_MAX;
    end else if (sum_fits) begin
      res_nxt = sum[W-1:0];
    end else begin
      res_nxt = sum[W+3] ? POS_MIN : POS_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (adv) out_valid_r <= dv_ctl.valid;
  end

  always_ff @(posedge clk) begin
    if (adv) out_pos_r <= res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = TDATA_W'(out_pos_r);

`ifndef SYNTHESIS
  // An oversized quotient must land on one of the range limits.
  a_ovf_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && dv_ctl.valid && dv_ovf && enable_r) |=>
      (out_pos_r == POS_MAX || out_pos_r == POS_MIN))
    else $error("overflowed term did not saturate");

  // In slope mode a position above the center always gets a nonzero term class.
  a_slope_class: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && v1_r && !mode_r && !d1_r[W] && d1_r != '0) |=> (cls2_r != CLS_ZERO))
    else $error("position above center classified as identity in slope mode");

  // Ramp and falling-peak segments always square a positive value.
  a_ramp_square: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && v2_r && (cls2_r == CLS_RAMP || cls2_r == CLS_MID)) |=> (sq3_r != '0))
    else $error("ramp segment squared a zero operand");
`endif

endmodule

@@ hdl/pqpw_div.sv @@
`timescale 1ns / 1ps
// Pipelined restoring divider with overflow detection: one quotient bit per stage.
// Depends on pqpw_pkg for the control struct.
module pqpw_div import pqpw_pkg::*; #(
  parameter int DW = 40,
  parameter int XW = 80,
  parameter int QW = 34,
  parameter int TW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  div_ctl_t      in_ctl,
  input  logic [XW-1:0] in_x,
  input  logic [DW-1:0] in_den,
  input  logic [TW-1:0] in_tag,
  output div_ctl_t      out_ctl,
  output logic [QW-1:0] out_q,
  output logic          out_ovf,
  output logic [TW-1:0] out_tag
);

  localparam int HW = XW - QW;

  div_ctl_t      ctl_r [QW+1];
  logic          ovf_r [QW+1];
  logic [DW-1:0] rem_r [QW+1];
  logic [QW-1:0] w_r   [QW+1];
  logic [DW-1:0] den_r [QW+1];
  logic [TW-1:0] tag_r [QW+1];

  logic ovf_nxt;

  // The quotient fits in QW bits only if the upper part of the dividend is below the divisor.
  assign ovf_nxt = in_x[XW-1:QW] >= {{(HW-DW){1'b0}}, in_den};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r[0] <= '0;
    end else if (adv) begin
      ctl_r[0] <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ovf_r[0] <= ovf_nxt;
      rem_r[0] <= in_x[QW +: DW];
      w_r[0]   <= in_x[QW-1:0];
      den_r[0] <= in_den;
      tag_r[0] <= in_tag;
    end
  end

  for (genvar g = 0; g < QW; g++) begin : g_step
    logic [DW:0] t_g;
    logic [DW:0] diff_g;
    logic        ge_g;

    assign t_g    = {rem_r[g], w_r[g][QW-1]};
    assign diff_g = t_g - {1'b0, den_r[g]};
    assign ge_g   = t_g >= {1'b0, den_r[g]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[g+1] <= '0;
      end else if (adv) begin
        ctl_r[g+1] <= ctl_r[g];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        ovf_r[g+1] <= ovf_r[g];
        rem_r[g+1] <= ge_g ? diff_g[DW-1:0] : t_g[DW-1:0];
        w_r[g+1]   <= {w_r[g][QW-2:0], ge_g};
        den_r[g+1] <= den_r[g];
        tag_r[g+1] <= tag_r[g];
      end
    end
  end

  assign out_ctl = ctl_r[QW];
  assign out_q   = w_r[QW];
  assign out_ovf = ovf_r[QW];
  assign out_tag = tag_r[QW];

endmodule
